/* rtl/ntpg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ntpg_pkg;

	localparam int IDX_W           = 12;
	localparam int VAL_W           = 16;
	localparam int TABLE_DEPTH_DEF = 2048;
	localparam int SEED_COUNT      = 11;
	localparam logic [VAL_W-1:0] FIRST_CAND = 16'd37;

	localparam int UPC_W  = 4;
	localparam int ACT_W  = 4;
	localparam int COND_W = 4;

	// Datapath actions.
	localparam logic [ACT_W-1:0] ACT_NOP         = 4'd0;
	localparam logic [ACT_W-1:0] ACT_ACCEPT      = 4'd1;
	localparam logic [ACT_W-1:0] ACT_READ_IDX    = 4'd2;
	localparam logic [ACT_W-1:0] ACT_LOAD_CAND   = 4'd3;
	localparam logic [ACT_W-1:0] ACT_READ_K      = 4'd4;
	localparam logic [ACT_W-1:0] ACT_LATCH_P     = 4'd5;
	localparam logic [ACT_W-1:0] ACT_SQUARE      = 4'd6;
	localparam logic [ACT_W-1:0] ACT_DIV_INIT    = 4'd7;
	localparam logic [ACT_W-1:0] ACT_DIV_STEP    = 4'd8;
	localparam logic [ACT_W-1:0] ACT_INC_K       = 4'd9;
	localparam logic [ACT_W-1:0] ACT_APPEND      = 4'd10;
	localparam logic [ACT_W-1:0] ACT_RESPOND     = 4'd11;
	localparam logic [ACT_W-1:0] ACT_RESPOND_OOR = 4'd12;

	// Jump conditions.
	localparam logic [COND_W-1:0] CND_NEVER    = 4'd0;
	localparam logic [COND_W-1:0] CND_ALWAYS   = 4'd1;
	localparam logic [COND_W-1:0] CND_NO_IN    = 4'd2;
	localparam logic [COND_W-1:0] CND_OOR      = 4'd3;
	localparam logic [COND_W-1:0] CND_FOUND    = 4'd4;
	localparam logic [COND_W-1:0] CND_K_END    = 4'd5;
	localparam logic [COND_W-1:0] CND_SQ_GT    = 4'd6;
	localparam logic [COND_W-1:0] CND_DIV_BUSY = 4'd7;
	localparam logic [COND_W-1:0] CND_REM_NZ   = 4'd8;
	localparam logic [COND_W-1:0] CND_OUT_FREE = 4'd9;

	// Program steps.
	localparam logic [UPC_W-1:0] S_FETCH  = 4'd0;
	localparam logic [UPC_W-1:0] S_RANGE  = 4'd1;
	localparam logic [UPC_W-1:0] S_LOOK   = 4'd2;
	localparam logic [UPC_W-1:0] S_CAND   = 4'd3;
	localparam logic [UPC_W-1:0] S_RDP    = 4'd4;
	localparam logic [UPC_W-1:0] S_LATCH  = 4'd5;
	localparam logic [UPC_W-1:0] S_SQ     = 4'd6;
	localparam logic [UPC_W-1:0] S_CMP    = 4'd7;
	localparam logic [UPC_W-1:0] S_DIV    = 4'd8;
	localparam logic [UPC_W-1:0] S_TEST   = 4'd9;
	localparam logic [UPC_W-1:0] S_NEXT   = 4'd10;
	localparam logic [UPC_W-1:0] S_APPEND = 4'd11;
	localparam logic [UPC_W-1:0] S_RESP   = 4'd12;
	localparam logic [UPC_W-1:0] S_RHOLD  = 4'd13;
	localparam logic [UPC_W-1:0] S_OOR    = 4'd14;
	localparam logic [UPC_W-1:0] S_OHOLD  = 4'd15;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [COND_W-1:0] cond;
		logic [UPC_W-1:0]  target;
	} ucode_t;

	typedef struct packed {
		logic no_in;
		logic oor;
		logic found;
		logic k_end;
		logic sq_gt;
		logic div_busy;
		logic rem_nz;
		logic out_free;
	} status_t;

	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
		ucode_t w;
		unique case (upc)
			S_FETCH:  w = '{ACT_ACCEPT,      CND_NO_IN,    S_FETCH};
			S_RANGE:  w = '{ACT_NOP,         CND_OOR,      S_OOR};
			S_LOOK:   w = '{ACT_READ_IDX,    CND_FOUND,    S_RESP};
			S_CAND:   w = '{ACT_LOAD_CAND,   CND_NEVER,    S_FETCH};
			S_RDP:    w = '{ACT_READ_K,      CND_K_END,    S_APPEND};
			S_LATCH:  w = '{ACT_LATCH_P,     CND_NEVER,    S_FETCH};
			S_SQ:     w = '{ACT_SQUARE,      CND_NEVER,    S_FETCH};
			S_CMP:    w = '{ACT_DIV_INIT,    CND_SQ_GT,    S_APPEND};
			S_DIV:    w = '{ACT_DIV_STEP,    CND_DIV_BUSY, S_DIV};
			S_TEST:   w = '{ACT_INC_K,       CND_REM_NZ,   S_RDP};
			S_NEXT:   w = '{ACT_NOP,         CND_ALWAYS,   S_CAND};
			S_APPEND: w = '{ACT_APPEND,      CND_ALWAYS,   S_LOOK};
			S_RESP:   w = '{ACT_RESPOND,     CND_OUT_FREE, S_FETCH};
			S_RHOLD:  w = '{ACT_NOP,         CND_ALWAYS,   S_RESP};
			S_OOR:    w = '{ACT_RESPOND_OOR, CND_OUT_FREE, S_FETCH};
			S_OHOLD:  w = '{ACT_NOP,         CND_ALWAYS,   S_OOR};
			default:  w = '{ACT_NOP,         CND_ALWAYS,   S_FETCH};
		endcase
		return w;
	endfunction

	function automatic logic [VAL_W-1:0] seed_prime(input logic [3:0] k);
		logic [VAL_W-1:0] v;
		unique case (k)
			4'd0:    v = 16'd2;
			4'd1:    v = 16'd3;
			4'd2:    v = 16'd5;
			4'd3:    v = 16'd7;
			4'd4:    v = 16'd11;
			4'd5:    v = 16'd13;
			4'd6:    v = 16'd17;
			4'd7:    v = 16'd19;
			4'd8:    v = 16'd23;
			4'd9:    v = 16'd29;
			4'd10:   v = 16'd31;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/ntpg_useq.sv */
`timescale 1ns / 1ps
`default_nettype none

module ntpg_useq
	import ntpg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire status_t          status,
	output logic [ACT_W-1:0]      act
);

	logic [UPC_W-1:0] upc_q;
	ucode_t           word;
	logic             take;

	assign word = ucode_rom(upc_q);
	assign act  = word.act;

	always_comb begin
		unique case (word.cond)
			CND_NEVER:    take = 1'b0;
			CND_ALWAYS:   take = 1'b1;
			CND_NO_IN:    take = status.no_in;
			CND_OOR:      take = status.oor;
			CND_FOUND:    take = status.found;
			CND_K_END:    take = status.k_end;
			CND_SQ_GT:    take = status.sq_gt;
			CND_DIV_BUSY: take = status.div_busy;
			CND_REM_NZ:   take = status.rem_nz;
			CND_OUT_FREE: take = status.out_free;
			default:      take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_FETCH;
		end else if (take) begin
			upc_q <= word.target;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/ntpg_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ntpg_dpath
	import ntpg_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [ACT_W-1:0] act,
	output status_t               status,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [IDX_W-1:0] index,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [VAL_W-1:0]      prime_value,
	output logic                  in_range
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(TABLE_DEPTH);
	localparam logic [3:0] DIV_LAST = 4'(VAL_W - 1);

	logic [VAL_W-1:0] mem [TABLE_DEPTH];

	logic [IDX_W-1:0]   idx_q;
	logic [CW-1:0]      found_q;
	logic [VAL_W-1:0]   next_q;
	logic [VAL_W-1:0]   cand_q;
	logic [CW-1:0]      k_q;
	logic [VAL_W-1:0]   p_q;
	logic [2*VAL_W-1:0] sq_q;
	logic [VAL_W-1:0]   rem_q;
	logic [VAL_W-1:0]   dw_q;
	logic [3:0]         div_cnt_q;
	logic [VAL_W-1:0]   rd_mem_q;
	logic [VAL_W-1:0]   seed_val_q;
	logic               seed_hit_q;
	logic               out_valid_q;
	logic [VAL_W-1:0]   out_value_q;
	logic               out_range_q;

	logic [AW-1:0]      rd_addr;
	logic [VAL_W-1:0]   rd_value;
	logic [VAL_W:0]     trial;
	logic [VAL_W:0]     trial_sub;
	logic               out_free;

	assign in_ready    = (act == ACT_ACCEPT);
	assign out_free    = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;
	assign prime_value = out_value_q;
	assign in_range    = out_range_q;

	assign rd_addr  = (act == ACT_READ_K) ? k_q[AW-1:0] : idx_q[AW-1:0];
	assign rd_value = seed_hit_q ? seed_val_q : rd_mem_q;

	assign trial     = {rem_q, dw_q[VAL_W-1]};
	assign trial_sub = trial - {1'b0, p_q};

	always_comb begin
		status.no_in    = !in_valid;
		status.oor      = {1'b0, idx_q} >= DEPTH_X;
		status.found    = {1'b0, idx_q} < (IDX_W + 1)'(found_q);
		status.k_end    = k_q >= found_q;
		status.sq_gt    = (p_q == '0) || (sq_q > {{VAL_W{1'b0}}, cand_q});
		status.div_busy = div_cnt_q != DIV_LAST;
		status.rem_nz   = rem_q != '0;
		status.out_free = out_free;
	end

	always_ff @(posedge clk) begin
		if (act == ACT_READ_IDX || act == ACT_READ_K) begin
			rd_mem_q   <= mem[rd_addr];
			seed_hit_q <= rd_addr < AW'(SEED_COUNT);
			seed_val_q <= seed_prime(rd_addr[3:0]);
		end
		if (act == ACT_APPEND) begin
			mem[found_q[AW-1:0]] <= cand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= CW'(SEED_COUNT);
			next_q      <= FIRST_CAND;
			out_valid_q <= 1'b0;
		end else begin
			if (act == ACT_LOAD_CAND) begin
				next_q <= next_q + 16'd2;
			end
			if (act == ACT_APPEND) begin
				found_q <= found_q + 1'b1;
			end
			if ((act == ACT_RESPOND || act == ACT_RESPOND_OOR) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (act)
			ACT_ACCEPT: begin
				if (in_valid) begin
					idx_q <= index;
				end
			end
			ACT_LOAD_CAND: begin
				cand_q <= next_q;
				k_q    <= CW'(1);
			end
			ACT_LATCH_P: begin
				p_q <= rd_value;
			end
			ACT_SQUARE: begin
				sq_q <= p_q * p_q;
			end
			ACT_DIV_INIT: begin
				rem_q     <= '0;
				dw_q      <= cand_q;
				div_cnt_q <= '0;
			end
			ACT_DIV_STEP: begin
				rem_q     <= trial_sub[VAL_W] ? trial[VAL_W-1:0] : trial_sub[VAL_W-1:0];
				dw_q      <= {dw_q[VAL_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			ACT_INC_K: begin
				k_q <= k_q + 1'b1;
			end
			ACT_RESPOND: begin
				if (out_free) begin
					out_value_q <= rd_value;
					out_range_q <= 1'b1;
				end
			end
			ACT_RESPOND_OOR: begin
				if (out_free) begin
					out_value_q <= '0;
					out_range_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/nth_prime_table_generator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    index[11:0]
// output    out_valid / out_ready  prime_value[15:0], in_range
//
// A query for a prime already in the table runs the microprogram's fetch, range, lookup
// and respond steps, and its result is registered in the output register. A query past
// the table skips the lookup. Extending the table costs one load step per candidate and,
// per trial divisor, read, latch, square, compare, bit-serial remainder and test steps;
// a rejected candidate adds one step, a prime adds a bound check of up to four steps,
// the append and a fresh lookup.
// Reset seeds the first eleven primes from a constant table; there is no clearing pass.
// A stalled result holds in the output register while the next query is taken.

module nth_prime_table_generator
	import ntpg_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [IDX_W-1:0] index,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [VAL_W-1:0]      prime_value,
	output logic                  in_range
);

	status_t          status;
	logic [ACT_W-1:0] act;

	ntpg_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.act    (act)
	);

	ntpg_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.act         (act),
		.status      (status),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.index       (index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.prime_value (prime_value),
		.in_range    (in_range)
	);

endmodule

`default_nettype wire

/* rtl/ntpg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ntpg_checker
	import ntpg_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic [IDX_W-1:0] index,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [VAL_W-1:0] prime_value,
	input wire logic             in_range
);

	// A result that was not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_value) && $stable(in_range))
		else $error("result changed before its transfer");

	// A query past the table answers with zero.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> prime_value == '0)
		else $error("out of range result is not zero");

	// Every prime delivered is at least two.
	a_prime_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_range |-> prime_value >= 16'd2)
		else $error("in range result below two");

	// After a query transfer the block does not take another query in the following cycle.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second query taken right after the first");

endmodule

bind nth_prime_table_generator ntpg_checker u_ntpg_checker (.*);

`default_nettype wire

/* sim/nth_prime_table_generator_test.sv */
`timescale 1ns / 1ps

module nth_prime_table_generator_test;
	import ntpg_pkg::*;

	localparam int DEPTH        = TABLE_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1000;
	localparam int TAIL_ITEMS   = 100;
	localparam int LONG_HOLD    = 80;
	localparam int TAIL_CYCLES  = 40;
	localparam int WATCHDOG     = 200000;

	typedef enum logic [1:0] {
		STEP_QUERY,
		STEP_HOLD,
		STEP_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		logic [IDX_W-1:0] idx;
	} plan_step_t;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             hit;
	} prime_answer_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic [IDX_W-1:0] index     = '0;
	logic             out_ready = 1'b0;
	logic             in_ready;
	logic             out_valid;
	logic [VAL_W-1:0] prime_value;
	logic             in_range;

	plan_step_t    query_plan[$];
	prime_answer_t owed_primes[$];

	logic [VAL_W-1:0] prime_tab[DEPTH];
	int unsigned      primes_found;
	int unsigned      next_odd;

	bit long_hold_req   = 1'b0;
	int send_gap        = 0;
	int take_hold       = 0;
	int send_idle_pct   = 10;
	int take_idle_pct   = 10;
	int sent            = 0;
	int received        = 0;
	int hits            = 0;
	int misses          = 0;
	int mismatches      = 0;
	int stuck           = 0;

	nth_prime_table_generator #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.index      (index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prime_value(prime_value),
		.in_range   (in_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Grows the table by trial division only as far as the query needs.
	function automatic void predict_prime(input logic [IDX_W-1:0] idx,
			output logic [VAL_W-1:0] value, output logic hit);
		int unsigned k;
		int unsigned p;
		int unsigned cand;
		bit          is_prime;
		if (idx >= DEPTH) begin
			value = '0;
			hit   = 1'b0;
			return;
		end
		while (primes_found <= idx && primes_found < DEPTH) begin
			cand     = next_odd;
			next_odd = (cand + 2) & 32'h00FF_FFFF;
			is_prime = 1'b1;
			for (k = 1; k < primes_found; k++) begin
				p = prime_tab[k];
				if (p == 0 || p * p > cand)
					break;
				if (cand % p == 0) begin
					is_prime = 1'b0;
					break;
				end
			end
			if (is_prime) begin
				prime_tab[primes_found] = VAL_W'(cand);
				primes_found++;
			end
		end
		value = prime_tab[idx];
		hit   = 1'b1;
	endfunction

	function automatic int pick_idle_pct();
		int r;
		r = $urandom_range(0, 2);
		return r * 15;
	endfunction

	task automatic plan_query(input int v);
		plan_step_t s;
		s.kind = STEP_QUERY;
		s.idx  = IDX_W'(v);
		query_plan.push_back(s);
	endtask

	task automatic plan_mark(input step_kind_t kind);
		plan_step_t s;
		s.kind = kind;
		s.idx  = '0;
		query_plan.push_back(s);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic             offer;
		logic [IDX_W-1:0] offer_idx;
		prime_answer_t    ans;
		if (!arst_n) begin
			in_valid <= 1'b0;
			index    <= '0;
		end else begin
			offer     = in_valid;
			offer_idx = index;
			if (in_valid && in_ready) begin
				predict_prime(index, ans.value, ans.hit);
				owed_primes.push_back(ans);
				sent++;
				if (sent % 40 == 0)
					send_idle_pct = pick_idle_pct();
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (query_plan.size() >= TAIL_ITEMS &&
						$urandom_range(0, 99) < send_idle_pct) begin
					send_gap = $urandom_range(1, 4) - 1;
				end else if (query_plan.size() > 0) begin
					case (query_plan[0].kind)
						STEP_QUERY: begin
							offer     = 1'b1;
							offer_idx = query_plan[0].idx;
							void'(query_plan.pop_front());
						end
						STEP_HOLD: begin
							long_hold_req = 1'b1;
							void'(query_plan.pop_front());
						end
						STEP_DRAIN: begin
							if (owed_primes.size() == 0)
								void'(query_plan.pop_front());
						end
						default: void'(query_plan.pop_front());
					endcase
				end
			end
			in_valid <= offer;
			index    <= offer_idx;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		prime_answer_t want;
		logic          take;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_primes.size() == 0) begin
					$error("result with nothing outstanding: prime_value %0d, in_range %0b",
						prime_value, in_range);
					mismatches++;
				end else begin
					want = owed_primes.pop_front();
					if (prime_value !== want.value) begin
						$error("prime_value: expected %0d, actual %0d", want.value, prime_value);
						mismatches++;
					end
					if (in_range !== want.hit) begin
						$error("in_range: expected %0b, actual %0b", want.hit, in_range);
						mismatches++;
					end
					if (want.hit)
						hits++;
					else
						misses++;
				end
				received++;
				if (received % 40 == 0)
					take_idle_pct = pick_idle_pct();
			end
			if (take_hold > 0) begin
				take_hold--;
				take = 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				take_hold     = LONG_HOLD - 1;
				take          = 1'b0;
			end else if (query_plan.size() >= TAIL_ITEMS &&
					$urandom_range(0, 99) < take_idle_pct) begin
				take_hold = $urandom_range(1, 4) - 1;
				take      = 1'b0;
			end else begin
				take = 1'b1;
			end
			out_ready <= take;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= WATCHDOG) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int seeds[SEED_COUNT];
		int reach;
		int pick;
		int n;
		seeds = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
		for (n = 0; n < SEED_COUNT; n++)
			prime_tab[n] = VAL_W'(seeds[n]);
		primes_found = SEED_COUNT;
		next_odd     = FIRST_CAND;

		plan_query(0);
		plan_query(10);
		plan_query(11);
		plan_query(4095);
		plan_query(DEPTH);
		plan_query(1);
		plan_query(12);
		plan_query(11);
		plan_query(0);
		plan_query(13);
		plan_query(20);
		plan_query(DEPTH + 1);
		plan_query(3);
		plan_query(3072);
		plan_query(2730);
		plan_mark(STEP_HOLD);
		plan_query(5);
		plan_query(21);
		plan_query(22);
		plan_query(9);
		plan_query(14);
		plan_query(4094);
		plan_query(22);
		plan_mark(STEP_DRAIN);
		reach = 22;

		// Mostly walk the frontier upward a few primes at a time so each
		// extension stays short, mixed with lookups and out-of-table queries.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				plan_mark(STEP_HOLD);
			if (n == 600)
				plan_mark(STEP_DRAIN);
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				reach = reach + $urandom_range(1, 8);
				if (reach > DEPTH - 1)
					reach = DEPTH - 1;
				plan_query(reach);
			end else if (pick < 80) begin
				plan_query($urandom_range(0, reach));
			end else if (pick < 92) begin
				plan_query($urandom_range(DEPTH, 4095));
			end else begin
				case ($urandom_range(0, 3))
					0: plan_query(0);
					1: plan_query(reach);
					2: plan_query(DEPTH);
					default: plan_query(4095);
				endcase
			end
		end
		while (reach < DEPTH - 1) begin
			reach = reach + 8;
			if (reach > DEPTH - 1)
				reach = DEPTH - 1;
			plan_query(reach);
		end
		plan_query(DEPTH - 1);
		plan_query(DEPTH - 2);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (query_plan.size() != 0 || in_valid || owed_primes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d lookups: %0d inside the table, %0d past its end.",
			received, hits, misses);
		$display("Table grown to %0d primes, the last one %0d.",
			primes_found, prime_tab[primes_found - 1]);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
